FILE: rtl/core/prj_pkg.sv
// ----------------------------------------------------------------------------
// prj_pkg
// Types, codes and helpers shared by the projection residual block.
// ----------------------------------------------------------------------------
package prj_pkg;

  localparam int DEF_MAX_ROWS       = 64;
  localparam int DEF_MAX_COMPONENTS = 8;
  localparam int DEF_MAX_COLUMNS    = 64;

  // command field widths, sized for the largest legal parameters
  localparam int IDX_W  = 10;
  localparam int KIDX_W = 5;
  localparam int CNT_W  = 11;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COMPONENTS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSPOSE  = 3'd3;

  localparam int WAIT_PIPE = 4;
  localparam int WAIT_OUT  = 2;

  typedef enum logic [1:0] {
    KIND_BASIS = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_SUM,
    OP_MAC,
    OP_PROJ,
    OP_FINAL
  } dp_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_OOR,
    S_SUM,
    S_SUMW,
    S_DIV,
    S_DIVW,
    S_MAC,
    S_MACW,
    S_PROJ,
    S_PROJW,
    S_FINAL,
    S_FINW
  } state_t;

  typedef struct packed {
    logic              wr_basis;
    logic              wr_data;
    logic              clr_acc;
    logic              clr_t;
    logic              div_start;
    logic              oor;
    dp_op_t            op;
    logic [IDX_W-1:0]  i;
    logic [IDX_W-1:0]  r;
    logic [IDX_W-1:0]  c;
    logic [KIDX_W-1:0] k;
    logic [CNT_W-1:0]  nr;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_status_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] o;
    if (v > 64'sh0000_0000_7fff_ffff) o = 32'sh7fff_ffff;
    else if (v < -64'sh0000_0000_8000_0000) o = -32'sh8000_0000;
    else o = v[31:0];
    return o;
  endfunction

endpackage

FILE: rtl/core/projection_residual_top.sv
// ----------------------------------------------------------------------------
// projection_residual_top
// Residual of a stored data matrix after removing its projection on a basis.
// ----------------------------------------------------------------------------
// Basis and data writes are taken while idle and leave busy low. A read
// walks the addressed column once for the sum and drains the read
// pipeline. It then divides by the row count one quotient bit per cycle.
// For each component it runs rows multiply-accumulates through the single
// shared multiplier, then drains and forms the projection, and it finishes
// with the final difference. The time is set by the one read port on each
// store and the one multiplier. An out-of-range read skips all of this.
// Each result is shown for exactly one cycle with strobe; the receiver
// cannot stall, and busy is low again in the cycle the result appears.
// ----------------------------------------------------------------------------
module projection_residual_top
  import prj_pkg::*;
#(
  parameter int MAX_ROWS       = DEF_MAX_ROWS,
  parameter int MAX_COMPONENTS = DEF_MAX_COMPONENTS,
  parameter int MAX_COLUMNS    = DEF_MAX_COLUMNS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           kind,
  input  logic [5:0]           row,
  input  logic [5:0]           col,
  input  logic signed [31:0]   value,
  output logic                 strobe,
  output logic signed [31:0]   result,
  output logic                 status,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t stat;

  prj_ctrl #(
    .MAX_ROWS(MAX_ROWS), .MAX_COMPONENTS(MAX_COMPONENTS), .MAX_COLUMNS(MAX_COLUMNS)
  ) u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .row(row), .col(col), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .stat(stat), .cmd(cmd)
  );

  prj_datapath #(
    .MAX_ROWS(MAX_ROWS), .MAX_COMPONENTS(MAX_COMPONENTS), .MAX_COLUMNS(MAX_COLUMNS)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .row(row), .col(col), .value(value),
    .stat(stat), .strobe(strobe), .result(result), .status(status)
  );

endmodule

FILE: rtl/core/prj_div.sv
// ----------------------------------------------------------------------------
// prj_div
// Signed by unsigned restoring divider, one quotient bit per cycle,
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
module prj_div #(
  parameter int SW = 40,
  parameter int DW = 7
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [SW-1:0] dividend,
  input  logic [DW-1:0]        divisor,
  output logic                 done,
  output logic signed [SW-1:0] quot
);

  localparam int NW = $clog2(SW + 1);

  logic [SW-1:0] mag;
  logic [SW-1:0] q;
  logic [DW:0]   rem;
  logic [DW:0]   rem_sh;
  logic [DW-1:0] dvs;
  logic          neg;
  logic          running;
  logic [NW-1:0] cnt;
  logic          fits;

  assign rem_sh = {rem[DW-1:0], mag[SW-1]};
  assign fits   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= NW'(SW);
        neg     <= dividend[SW-1];
        mag     <= dividend[SW-1] ? SW'(-dividend) : dividend;
        rem     <= '0;
        dvs     <= divisor;
      end else if (running) begin
        rem <= fits ? rem_sh - {1'b0, dvs} : rem_sh;
        q   <= {q[SW-2:0], fits};
        mag <= {mag[SW-2:0], 1'b0};
        cnt <= cnt - NW'(1);
        if (cnt == NW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign quot = neg ? -$signed(q) : $signed(q);

endmodule

FILE: rtl/core/prj_datapath.sv
// ----------------------------------------------------------------------------
// prj_datapath
// Stores, read pipeline, shared multiplier, accumulators and result register.
// ----------------------------------------------------------------------------
module prj_datapath
  import prj_pkg::*;
#(
  parameter int MAX_ROWS       = DEF_MAX_ROWS,
  parameter int MAX_COMPONENTS = DEF_MAX_COMPONENTS,
  parameter int MAX_COLUMNS    = DEF_MAX_COLUMNS
) (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  input  logic [5:0]         row,
  input  logic [5:0]         col,
  input  logic signed [31:0] value,
  output dp_status_t         stat,
  output logic               strobe,
  output logic signed [31:0] result,
  output logic               status
);

  localparam int RW  = $clog2(MAX_ROWS);
  localparam int CW  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int KW  = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
  localparam int DAW = $clog2(MAX_ROWS * MAX_COLUMNS);
  localparam int BAW = $clog2(MAX_ROWS * MAX_COMPONENTS);
  localparam int NRW = $clog2(MAX_ROWS + 1);
  localparam int SW  = 33 + $clog2(MAX_ROWS);
  localparam int TW  = 49 + $clog2(MAX_ROWS);
  localparam int PW  = 49 + KW;

  logic [31:0] dmem [MAX_ROWS * MAX_COLUMNS];
  logic [31:0] bmem [MAX_ROWS * MAX_COMPONENTS];

  logic [RW-1:0]  d_row, b_row;
  logic [DAW-1:0] d_raddr, d_waddr;
  logic [BAW-1:0] b_raddr, b_waddr;

  always_comb begin
    d_row   = (cmd.op == OP_FINAL) ? cmd.r[RW-1:0] : cmd.i[RW-1:0];
    b_row   = (cmd.op == OP_PROJ) ? cmd.r[RW-1:0] : cmd.i[RW-1:0];
    d_raddr = DAW'(d_row) * DAW'(MAX_COLUMNS) + DAW'(cmd.c[CW-1:0]);
    b_raddr = BAW'(b_row) * BAW'(MAX_COMPONENTS) + BAW'(cmd.k[KW-1:0]);
    d_waddr = DAW'(RW'(row)) * DAW'(MAX_COLUMNS) + DAW'(CW'(col));
    b_waddr = BAW'(RW'(row)) * BAW'(MAX_COMPONENTS) + BAW'(KW'(col));
  end

  logic [31:0] d_q, b_q;

  always_ff @(posedge clk) begin
    if (cmd.wr_data) dmem[d_waddr] <= value;
    d_q <= dmem[d_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_basis) bmem[b_waddr] <= value;
    b_q <= bmem[b_raddr];
  end

  dp_op_t op1, op2, op3;

  always_ff @(posedge clk) begin
    if (rst) begin
      op1 <= OP_NONE;
      op2 <= OP_NONE;
      op3 <= OP_NONE;
    end else begin
      op1 <= cmd.op;
      op2 <= op1;
      op3 <= op2;
    end
  end

  // column sum and mean
  logic signed [SW-1:0] sacc;
  logic signed [SW-1:0] quot;
  logic signed [31:0]   mean;

  prj_div #(.SW(SW), .DW(NRW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (sacc),
    .divisor  (cmd.nr[NRW-1:0]),
    .done     (stat.div_done),
    .quot     (quot)
  );

  always_ff @(posedge clk) begin
    if (cmd.clr_acc) sacc <= '0;
    else if (op1 == OP_SUM) sacc <= sacc + SW'($signed(d_q));
    if (stat.div_done) mean <= quot[31:0];
  end

  // stage 1: centering
  logic signed [32:0] diff;
  logic signed [31:0] cen, b1, d1;

  assign diff = 33'($signed(d_q)) - 33'(mean);

  always_ff @(posedge clk) begin
    cen <= sat32(64'(diff));
    b1  <= $signed(b_q);
    d1  <= $signed(d_q);
  end

  // stage 2: shared multiplier, final difference
  logic signed [TW-1:0] tacc;
  logic signed [PW-1:0] pacc;
  logic signed [31:0]   tsat;
  logic signed [31:0]   mul_a;
  logic signed [63:0]   prod;
  logic signed [47:0]   prod_sh;
  logic signed [PW:0]   res_w;

  assign mul_a   = (op2 == OP_MAC) ? cen : tsat;
  assign prod_sh = prod[63:16];
  assign res_w   = (PW + 1)'(d1) - (PW + 1)'(pacc);

  always_ff @(posedge clk) begin
    prod <= 64'(b1) * 64'(mul_a);
    tsat <= sat32(64'(tacc));
  end

  // stage 3: accumulate floor(product / 2^16)
  always_ff @(posedge clk) begin
    if (cmd.clr_t) tacc <= '0;
    else if (op3 == OP_MAC) tacc <= tacc + TW'(prod_sh);
    if (cmd.clr_acc) pacc <= '0;
    else if (op3 == OP_PROJ) pacc <= pacc + PW'(prod_sh);
  end

  always_ff @(posedge clk) begin
    if (rst) strobe <= 1'b0;
    else strobe <= cmd.oor || (op2 == OP_FINAL);
    status <= cmd.oor;
    result <= cmd.oor ? 32'sd0 : sat32(64'(res_w));
  end

endmodule

FILE: rtl/core/prj_ctrl.sv
// ----------------------------------------------------------------------------
// prj_ctrl
// Configuration registers and the read sequencer.
// ----------------------------------------------------------------------------
module prj_ctrl
  import prj_pkg::*;
#(
  parameter int MAX_ROWS       = DEF_MAX_ROWS,
  parameter int MAX_COMPONENTS = DEF_MAX_COMPONENTS,
  parameter int MAX_COLUMNS    = DEF_MAX_COLUMNS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           kind,
  input  logic [5:0]           row,
  input  logic [5:0]           col,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  dp_status_t           stat,
  output dp_cmd_t              cmd
);

  localparam int RW  = $clog2(MAX_ROWS);
  localparam int CW  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int KW  = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
  localparam int NRW = $clog2(MAX_ROWS + 1);
  localparam int NKW = $clog2(MAX_COMPONENTS + 1);
  localparam int NCW = $clog2(MAX_COLUMNS + 1);

  logic [6:0] rows_in_use, columns_in_use;
  logic [3:0] components_in_use;
  logic       transpose_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use       <= 7'd64;
      components_in_use <= 4'd1;
      columns_in_use    <= 7'd64;
      transpose_out     <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ROWS:       rows_in_use       <= cfg_data[6:0];
        CFG_COMPONENTS: components_in_use <= cfg_data[3:0];
        CFG_COLUMNS:    columns_in_use    <= cfg_data[6:0];
        CFG_TRANSPOSE:  transpose_out     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [NRW-1:0] nr;
  logic [NKW-1:0] nk;
  logic [NCW-1:0] nc;

  always_comb begin
    if (rows_in_use == 7'd0) nr = NRW'(1);
    else if (int'(rows_in_use) > MAX_ROWS) nr = NRW'(MAX_ROWS);
    else nr = NRW'(rows_in_use);
    nk = (int'(components_in_use) > MAX_COMPONENTS) ? NKW'(MAX_COMPONENTS)
                                                    : NKW'(components_in_use);
    nc = (int'(columns_in_use) > MAX_COLUMNS) ? NCW'(MAX_COLUMNS)
                                              : NCW'(columns_in_use);
  end

  logic       accept;
  logic [5:0] r6, c6;
  logic       out_range;

  assign accept    = start && !busy;
  assign r6        = transpose_out ? col : row;
  assign c6        = transpose_out ? row : col;
  assign out_range = (int'(r6) >= int'(nr)) || (int'(c6) >= int'(nc));

  state_t        state, state_next;
  logic [RW-1:0] i;
  logic [KW-1:0] k;
  logic [2:0]    cnt;
  logic [RW-1:0] r_q;
  logic [CW-1:0] c_q;
  logic          i_last, k_last, pipe_done, out_done;

  assign i_last    = i == RW'(nr - NRW'(1));
  assign k_last    = k == KW'(nk - NKW'(1));
  assign pipe_done = cnt == 3'(WAIT_PIPE - 1);
  assign out_done  = cnt == 3'(WAIT_OUT - 1);

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept) begin
      r_q <= RW'(r6);
      c_q <= CW'(c6);
    end
    if (state == S_SUM || state == S_MAC) i <= i + RW'(1);
    else i <= '0;
    if (state == S_IDLE) k <= '0;
    else if (state == S_PROJW && pipe_done) k <= k + KW'(1);
    if (state == S_SUMW || state == S_MACW || state == S_PROJW || state == S_FINW)
      cnt <= cnt + 3'd1;
    else cnt <= '0;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept && kind == KIND_READ) state_next = out_range ? S_OOR : S_SUM;
      S_OOR:   state_next = S_IDLE;
      S_SUM:   if (i_last) state_next = S_SUMW;
      S_SUMW:  if (pipe_done) state_next = S_DIV;
      S_DIV:   state_next = S_DIVW;
      S_DIVW:  if (stat.div_done) state_next = (nk == '0) ? S_FINAL : S_MAC;
      S_MAC:   if (i_last) state_next = S_MACW;
      S_MACW:  if (pipe_done) state_next = S_PROJ;
      S_PROJ:  state_next = S_PROJW;
      S_PROJW: if (pipe_done) state_next = k_last ? S_FINAL : S_MAC;
      S_FINAL: state_next = S_FINW;
      S_FINW:  if (out_done) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy          = state != S_IDLE;
    cmd           = '0;
    cmd.op        = OP_NONE;
    cmd.i         = IDX_W'(i);
    cmd.r         = IDX_W'(r_q);
    cmd.c         = IDX_W'(c_q);
    cmd.k         = KIDX_W'(k);
    cmd.nr        = CNT_W'(nr);
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.wr_basis = kind == KIND_BASIS && int'(row) < MAX_ROWS
                         && int'(col) < MAX_COMPONENTS;
          cmd.wr_data  = kind == KIND_DATA && int'(row) < MAX_ROWS
                         && int'(col) < MAX_COLUMNS;
          cmd.clr_acc  = kind == KIND_READ;
        end
      end
      S_OOR:   cmd.oor = 1'b1;
      S_SUM:   cmd.op = OP_SUM;
      S_DIV:   cmd.div_start = 1'b1;
      S_DIVW:  cmd.clr_t = 1'b1;
      S_MAC:   cmd.op = OP_MAC;
      S_PROJ:  cmd.op = OP_PROJ;
      S_PROJW: cmd.clr_t = pipe_done;
      S_FINAL: cmd.op = OP_FINAL;
      default: ;
    endcase
  end

endmodule

FILE: rtl/core/prj_checker.sv
// ----------------------------------------------------------------------------
// prj_checker
// Port-level checks on the projection residual block.
// ----------------------------------------------------------------------------
module prj_checker
  import prj_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic [1:0]         kind,
  input logic               strobe,
  input logic signed [31:0] result,
  input logic               status
);

  // a read holds the block busy until its word comes out
  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && kind == KIND_READ |=> busy)
    else $error("read accepted but block not busy");

  // writes and unused kinds finish in the cycle they are taken
  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    start && !busy && kind != KIND_READ |=> !busy && !strobe)
    else $error("non-read item left block busy or gave a word");

  a_strobe_idle: assert property (@(posedge clk) disable iff (rst)
    strobe |-> !busy)
    else $error("result word while still busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (rst)
    strobe |=> !strobe)
    else $error("two result words back to back");

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    strobe && status |-> result == 32'sd0)
    else $error("out-of-range read with nonzero result");

endmodule

bind projection_residual_top prj_checker u_prj_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
  .strobe(strobe), .result(result), .status(status)
);
